>>> rtl/blob_centroid_bbox_binner_top_assert.svh
// Assertion macros for the blob centroid and box binner.
// Used by modules that have clk and rst in scope; no other dependencies.
`ifndef BLOB_CENTROID_BBOX_BINNER_TOP_ASSERT_SVH
`define BLOB_CENTROID_BBOX_BINNER_TOP_ASSERT_SVH

// same-cycle implication
`define BCBB_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcbb check failed");

// next-cycle implication
`define BCBB_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcbb check failed");

`endif

>>> rtl/bcbb_pkg.sv
// Shared types and constants for the blob centroid and box binner.
// No dependencies.
package bcbb_pkg;
  localparam int MAX_DIM    = 4096;
  localparam int MAX_LEVELS = 64;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int LVL_W      = 7;
  localparam int CNT_W      = 25;
  localparam int SUM_W      = 36;
  localparam int NUM_W      = 37;
  localparam int DEN_W      = 26;
  localparam int ADDR_W     = 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MARGIN = 2'd2;
  localparam logic [1:0] REG_LEVELS = 2'd3;

  typedef enum logic [1:0] {
    OP_CX = 2'd0,
    OP_CY = 2'd1,
    OP_BX = 2'd2,
    OP_BY = 2'd3
  } div_op_t;

  typedef struct packed {
    logic    div_start;
    div_op_t div_op;
    logic    cap_en;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic snap_valid;
    logic found;
    logic edge_hit;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;
endpackage

>>> rtl/bcbb_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on bcbb_pkg.
module bcbb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bcbb_pkg::NUM_W-1:0] num,
  input  logic [bcbb_pkg::DEN_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [bcbb_pkg::NUM_W-1:0] quot
);
  import bcbb_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   trial;
  logic             take;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= take ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      quot   <= {quot[NUM_W-2:0], take};
    end
  end
endmodule

>>> rtl/bcbb_dp.sv
// Datapath: config registers, pixel accumulators, frame snapshot, divider, result register.
// Depends on bcbb_pkg and bcbb_div.
module bcbb_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcbb_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   mask_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic                         near_edge,
  output logic [bcbb_pkg::POS_W-1:0]   center_x,
  output logic [bcbb_pkg::POS_W-1:0]   center_y,
  output logic [bcbb_pkg::POS_W-1:0]   box_min_x,
  output logic [bcbb_pkg::POS_W-1:0]   box_max_x,
  output logic [bcbb_pkg::POS_W-1:0]   box_min_y,
  output logic [bcbb_pkg::POS_W-1:0]   box_max_y,
  output logic [bcbb_pkg::CNT_W-1:0]   pixel_total,
  output logic [bcbb_pkg::LVL_W-1:0]   column_bin,
  output logic [bcbb_pkg::LVL_W-1:0]   row_bin,
  input  bcbb_pkg::cmd_t               cmd,
  output bcbb_pkg::sts_t               sts
);
  import bcbb_pkg::*;

  // config
  logic [DIM_W-1:0] image_width, image_height;
  logic [7:0]       edge_margin;
  logic [LVL_W-1:0] bin_levels;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [LVL_W-1:0] lv_eff;
  logic             cfg_wr;

  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      edge_margin  <= 8'd42;
      bin_levels   <= LVL_W'(5);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_MARGIN: edge_margin  <= pwdata[7:0];
        REG_LEVELS: bin_levels   <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_MARGIN: prdata = 32'(edge_margin);
      REG_LEVELS: prdata = 32'(bin_levels);
      default:    prdata = '0;
    endcase
  end

  assign w_eff = (image_width == '0) ? DIM_W'(1) :
                 (image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
  assign h_eff = (image_height == '0) ? DIM_W'(1) :
                 (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
  assign lv_eff = (bin_levels == '0) ? LVL_W'(1) :
                  (bin_levels > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : bin_levels;

  // accumulators
  logic [POS_W-1:0] col_pos, row_pos;
  logic [CNT_W-1:0] hit_count, hit_next;
  logic [SUM_W-1:0] col_sum, row_sum, col_sum_next, row_sum_next;
  logic [POS_W-1:0] min_col, max_col, min_row, max_row;
  logic [POS_W-1:0] min_col_next, max_col_next, min_row_next, max_row_next;
  logic             hit, last_col, last_row, frame_end, in_fire;

  assign hit       = mask_value != 8'd0;
  assign last_col  = ({1'b0, col_pos} + 1'b1) >= w_eff;
  assign last_row  = ({1'b0, row_pos} + 1'b1) >= h_eff;
  assign frame_end = last_col & last_row;
  assign in_ready  = !sts.snap_valid || !frame_end;
  assign in_fire   = in_valid & in_ready;

  always_comb begin
    hit_next     = hit_count;
    col_sum_next = col_sum;
    row_sum_next = row_sum;
    min_col_next = min_col;
    max_col_next = max_col;
    min_row_next = min_row;
    max_row_next = max_row;
    if (hit) begin
      hit_next     = hit_count + 1'b1;
      col_sum_next = col_sum + SUM_W'(col_pos);
      row_sum_next = row_sum + SUM_W'(row_pos);
      if (col_pos < min_col) min_col_next = col_pos;
      if (col_pos > max_col) max_col_next = col_pos;
      if (row_pos < min_row) min_row_next = row_pos;
      if (row_pos > max_row) max_row_next = row_pos;
    end
  end

  // snapshot of a finished frame
  logic             snap_valid;
  logic [CNT_W-1:0] s_hit;
  logic [SUM_W-1:0] s_col_sum, s_row_sum;
  logic [POS_W-1:0] s_min_col, s_max_col, s_min_row, s_max_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      hit_count  <= '0;
      col_sum    <= '0;
      row_sum    <= '0;
      min_col    <= '1;
      max_col    <= '0;
      min_row    <= '1;
      max_row    <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (cmd.out_load) snap_valid <= 1'b0;
      if (in_fire) begin
        col_pos <= last_col ? '0 : col_pos + 1'b1;
        if (last_col) row_pos <= last_row ? '0 : row_pos + 1'b1;
        if (frame_end) begin
          snap_valid <= 1'b1;
          hit_count  <= '0;
          col_sum    <= '0;
          row_sum    <= '0;
          min_col    <= '1;
          max_col    <= '0;
          min_row    <= '1;
          max_row    <= '0;
        end else begin
          hit_count <= hit_next;
          col_sum   <= col_sum_next;
          row_sum   <= row_sum_next;
          min_col   <= min_col_next;
          max_col   <= max_col_next;
          min_row   <= min_row_next;
          max_row   <= max_row_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && frame_end) begin
      s_hit     <= hit_next;
      s_col_sum <= col_sum_next;
      s_row_sum <= row_sum_next;
      s_min_col <= min_col_next;
      s_max_col <= max_col_next;
      s_min_row <= min_row_next;
      s_max_row <= max_row_next;
    end
  end

  // edge test: max >= w - margin, rewritten as max + margin >= w; or min <= margin
  logic s_found, s_edge;
  assign s_found = s_hit != '0;
  assign s_edge  = ({2'b0, s_max_col} + 14'(edge_margin) >= {1'b0, w_eff}) ||
                   (s_min_col <= POS_W'(edge_margin));

  // divider and its operands
  logic [NUM_W-1:0] div_num, div_q;
  logic [DEN_W-1:0] div_den;
  logic             div_busy, div_done;
  logic [POS_W-1:0] cx_r, cy_r;
  logic [LVL_W-1:0] held_col_bin, held_row_bin, bin_val;

  always_comb begin
    unique case (cmd.div_op)
      OP_CX: begin
        div_num = {s_col_sum, 1'b0} + NUM_W'(s_hit);
        div_den = {s_hit, 1'b0};
      end
      OP_CY: begin
        div_num = {s_row_sum, 1'b0} + NUM_W'(s_hit);
        div_den = {s_hit, 1'b0};
      end
      OP_BX: begin
        div_num = NUM_W'(cx_r) * NUM_W'(lv_eff);
        div_den = DEN_W'(w_eff);
      end
      OP_BY: begin
        div_num = NUM_W'(cy_r) * NUM_W'(lv_eff);
        div_den = DEN_W'(h_eff);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  bcbb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // bin = q + 1, capped at levels
  assign bin_val = (div_q >= NUM_W'(lv_eff)) ? lv_eff : LVL_W'(div_q + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.cap_en && cmd.div_op == OP_CX) cx_r <= div_q[POS_W-1:0];
    if (cmd.cap_en && cmd.div_op == OP_CY) cy_r <= div_q[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_col_bin <= '0;
      held_row_bin <= '0;
    end else if (cmd.cap_en) begin
      if (cmd.div_op == OP_BX) held_col_bin <= bin_val;
      if (cmd.div_op == OP_BY) held_row_bin <= bin_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= s_found;
      near_edge   <= !s_found || s_edge;
      center_x    <= s_found ? cx_r : '0;
      center_y    <= s_found ? cy_r : '0;
      box_min_x   <= s_found ? s_min_col : '0;
      box_max_x   <= s_found ? s_max_col : '0;
      box_min_y   <= s_found ? s_min_row : '0;
      box_max_y   <= s_found ? s_max_row : '0;
      pixel_total <= s_hit;
      column_bin  <= held_col_bin;
      row_bin     <= held_row_bin;
    end
  end

  assign sts.snap_valid = snap_valid;
  assign sts.found      = s_found;
  assign sts.edge_hit   = s_edge;
  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_ready;
endmodule

>>> rtl/bcbb_ctrl.sv
// End-of-frame sequencer: centroid divisions, bin divisions, result hand-off.
// Depends on bcbb_pkg and the assertion header.
`include "blob_centroid_bbox_binner_top_assert.svh"
module bcbb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  bcbb_pkg::sts_t sts,
  output bcbb_pkg::cmd_t cmd
);
  import bcbb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CX   = 6'b000010,
    S_CY   = 6'b000100,
    S_BX   = 6'b001000,
    S_BY   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next    = state;
    cmd.div_start = 1'b0;
    cmd.div_op    = OP_CX;
    cmd.cap_en    = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (sts.snap_valid) begin
          if (sts.found) begin
            cmd.div_start = 1'b1;
            state_next    = S_CX;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_CX: begin
        if (sts.div_done) begin
          cmd.cap_en = 1'b1;
          state_next = S_CY;
        end
      end
      S_CY: begin
        cmd.div_op = OP_CY;
        if (sts.div_done) begin
          cmd.cap_en = 1'b1;
          state_next = S_BX;
        end else if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
        end
      end
      S_BX: begin
        cmd.div_op = OP_BX;
        if (sts.edge_hit) begin
          state_next = S_OUT;
        end else if (sts.div_done) begin
          cmd.cap_en = 1'b1;
          state_next = S_BY;
        end else if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
        end
      end
      S_BY: begin
        cmd.div_op = OP_BY;
        if (sts.div_done) begin
          cmd.cap_en = 1'b1;
          state_next = S_OUT;
        end else if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a start in CY/BX/BY fires only on entry: divider goes busy next cycle
  logic started;
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= 1'b0;
    end
  end

  `BCBB_IMPL(a_start_when_idle, cmd.div_start, !sts.div_busy && !started)
  `BCBB_IMPL(a_load_needs_slot, cmd.out_load, sts.out_free && sts.snap_valid)
  `BCBB_NEXT(a_load_returns_idle, cmd.out_load, state == S_IDLE && !sts.div_busy)
  `BCBB_IMPL(a_div_only_found, cmd.div_start, sts.found)
endmodule

>>> rtl/blob_centroid_bbox_binner_top.sv
// Blob centroid / bounding-box binner, top level.
// Depends on bcbb_pkg, bcbb_dp, bcbb_ctrl.
//
// Takes a thresholded mask frame in raster order, one pixel per transaction,
// at one pixel per clock unless stalled. Nonzero pixels are counted, their
// column/row sums accumulated and the bounding box widened. On the last pixel
// of a frame the totals move to a snapshot and the accumulators clear, so the
// next frame streams in straight away. The snapshot is then worked through by
// a shared serial divider (one quotient bit per clock): centroid X and Y, and,
// when the box clears both side margins, the column and row bins. An empty
// frame skips the divisions. This work overlaps the next frame's pixels.
// The only stall is the last pixel of a frame arriving while the previous
// snapshot is still busy or still waits for the output register to free.
// Results sit in an output register; the next frame runs while one waits.
// Config (APB, pready always high): 0x0 width, 0x4 height, 0x8 edge margin,
// 0xC bin levels. Write only while idle.
module blob_centroid_bbox_binner_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcbb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  mask_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic                        near_edge,
  output logic [bcbb_pkg::POS_W-1:0]  center_x,
  output logic [bcbb_pkg::POS_W-1:0]  center_y,
  output logic [bcbb_pkg::POS_W-1:0]  box_min_x,
  output logic [bcbb_pkg::POS_W-1:0]  box_max_x,
  output logic [bcbb_pkg::POS_W-1:0]  box_min_y,
  output logic [bcbb_pkg::POS_W-1:0]  box_max_y,
  output logic [bcbb_pkg::CNT_W-1:0]  pixel_total,
  output logic [bcbb_pkg::LVL_W-1:0]  column_bin,
  output logic [bcbb_pkg::LVL_W-1:0]  row_bin
);
  import bcbb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // no wait states on the register port
  assign pready = 1'b1;

  bcbb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mask_value  (mask_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .near_edge   (near_edge),
    .center_x    (center_x),
    .center_y    (center_y),
    .box_min_x   (box_min_x),
    .box_max_x   (box_max_x),
    .box_min_y   (box_min_y),
    .box_max_y   (box_max_y),
    .pixel_total (pixel_total),
    .column_bin  (column_bin),
    .row_bin     (row_bin),
    .cmd         (cmd),
    .sts         (sts)
  );

  // sequencer for the end-of-frame divisions
  bcbb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );
endmodule

>>> test/blob_centroid_bbox_binner_top_tb.sv
// Testbench for the blob centroid / bounding-box binner top level.
// Depends on bcbb_pkg and blob_centroid_bbox_binner_top; self-checking, no files.
module blob_centroid_bbox_binner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcbb_pkg::*;

  typedef struct packed {
    logic             found;
    logic             near_edge;
    logic [POS_W-1:0] center_x;
    logic [POS_W-1:0] center_y;
    logic [POS_W-1:0] box_min_x;
    logic [POS_W-1:0] box_max_x;
    logic [POS_W-1:0] box_min_y;
    logic [POS_W-1:0] box_max_y;
    logic [CNT_W-1:0] pixel_total;
    logic [LVL_W-1:0] column_bin;
    logic [LVL_W-1:0] row_bin;
  } blob_report_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [7:0] mask_value;
  blob_report_t got;

  blob_centroid_bbox_binner_top DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .mask_value(mask_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(got.found), .near_edge(got.near_edge),
    .center_x(got.center_x), .center_y(got.center_y),
    .box_min_x(got.box_min_x), .box_max_x(got.box_max_x),
    .box_min_y(got.box_min_y), .box_max_y(got.box_max_y),
    .pixel_total(got.pixel_total), .column_bin(got.column_bin), .row_bin(got.row_bin)
  );

  // predictor copy of the registers and accumulators
  int unsigned cfg_width, cfg_height, cfg_margin, cfg_levels;
  int unsigned col_at, row_at, hits, lo_col, hi_col, lo_row, hi_row;
  int unsigned keep_col_bin, keep_row_bin;
  longint unsigned sum_col, sum_row;

  logic [7:0]   pixel_queue[$];
  blob_report_t report_queue[$];
  int errors, frames_seen, pixels_sent;
  bit hold_sender;
  bit in_took;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned bin_index(int unsigned c, int unsigned lv,
                                            int unsigned dim);
    longint unsigned b;
    b = (longint'(c) * lv) / dim + 1;
    if (b > lv) b = lv;
    return b;
  endfunction

  function automatic int unsigned round_mean(longint unsigned s, int unsigned n);
    return (2 * s + n) / (2 * longint'(n));
  endfunction

  task automatic clear_accumulators();
    col_at = 0; row_at = 0; hits = 0; sum_col = 0; sum_row = 0;
    lo_col = 32'hFFFF_FFFF; hi_col = 0; lo_row = 32'hFFFF_FFFF; hi_row = 0;
  endtask

  // advance the predictor by one accepted pixel
  task automatic predict_pixel(logic [7:0] px);
    int unsigned w, h, lv;
    bit edge_flag;
    blob_report_t r;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    if (px != 0) begin
      hits = (hits + 1) & 32'h1FF_FFFF;
      sum_col = (sum_col + col_at) & 64'hF_FFFF_FFFF;
      sum_row = (sum_row + row_at) & 64'hF_FFFF_FFFF;
      if (col_at < lo_col) lo_col = col_at;
      if (col_at > hi_col) hi_col = col_at;
      if (row_at < lo_row) lo_row = row_at;
      if (row_at > hi_row) hi_row = row_at;
    end
    if (col_at + 1 < w) begin
      col_at++;
      return;
    end
    col_at = 0;
    if (row_at + 1 < h) begin
      row_at++;
      return;
    end
    r = '0;
    r.found = (hits != 0);
    edge_flag = 1;
    if (r.found) begin
      r.center_x = round_mean(sum_col, hits);
      r.center_y = round_mean(sum_row, hits);
      r.box_min_x = lo_col; r.box_max_x = hi_col;
      r.box_min_y = lo_row; r.box_max_y = hi_row;
      edge_flag = (longint'(hi_col) >= longint'(w) - longint'(cfg_margin)) ||
                  (lo_col <= cfg_margin);
      if (!edge_flag) begin
        lv = (cfg_levels == 0) ? 1 : (cfg_levels > MAX_LEVELS ? MAX_LEVELS : cfg_levels);
        keep_col_bin = bin_index(round_mean(sum_col, hits), lv, w) & 7'h7F;
        keep_row_bin = bin_index(round_mean(sum_row, hits), lv, h) & 7'h7F;
      end
    end
    r.near_edge = edge_flag;
    r.pixel_total = hits;
    r.column_bin = keep_col_bin;
    r.row_bin = keep_row_bin;
    report_queue.push_back(r);
    clear_accumulators();
  endtask

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    $display("mismatch frame %0d %s: expected %0d got %0d", frames_seen, what, exp_v,
             got_v);
    errors++;
  endtask

  // driver: one pixel transaction at a time, random gap before each
  int gap_in;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
      gap_in <= $urandom_range(0, 7);
    end else if (in_valid && !in_took) begin
      // not yet taken: hold payload
    end else if (gap_in > 0 || hold_sender || pixel_queue.size() == 0) begin
      in_valid <= 0;
      if (gap_in > 0) gap_in <= gap_in - 1;
    end else begin
      in_valid <= 1;
      mask_value <= pixel_queue.pop_front();
      gap_in <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end
  end

  // predictor fed on acceptance; also tells the driver the pixel was taken
  always @(posedge clk) begin
    in_took = !rst && in_valid && in_ready;
    if (in_took) begin
      predict_pixel(mask_value);
      pixels_sent++;
    end
  end

  // receiver stalls
  int stall_out;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
      stall_out <= 0;
    end else if (stall_out > 0) begin
      out_ready <= 0;
      stall_out <= stall_out - 1;
    end else begin
      out_ready <= 1;
      if (out_valid) stall_out <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    blob_report_t e;
    if (!rst && out_valid && out_ready) begin
      if (report_queue.size() == 0) begin
        $display("unexpected result transaction");
        errors++;
      end else begin
        e = report_queue.pop_front();
        if (got.found !== e.found) report_mismatch("found", e.found, got.found);
        if (got.near_edge !== e.near_edge)
          report_mismatch("near_edge", e.near_edge, got.near_edge);
        if (got.center_x !== e.center_x) report_mismatch("center_x", e.center_x, got.center_x);
        if (got.center_y !== e.center_y) report_mismatch("center_y", e.center_y, got.center_y);
        if (got.box_min_x !== e.box_min_x)
          report_mismatch("box_min_x", e.box_min_x, got.box_min_x);
        if (got.box_max_x !== e.box_max_x)
          report_mismatch("box_max_x", e.box_max_x, got.box_max_x);
        if (got.box_min_y !== e.box_min_y)
          report_mismatch("box_min_y", e.box_min_y, got.box_min_y);
        if (got.box_max_y !== e.box_max_y)
          report_mismatch("box_max_y", e.box_max_y, got.box_max_y);
        if (got.pixel_total !== e.pixel_total)
          report_mismatch("pixel_total", e.pixel_total, got.pixel_total);
        if (got.column_bin !== e.column_bin)
          report_mismatch("column_bin", e.column_bin, got.column_bin);
        if (got.row_bin !== e.row_bin) report_mismatch("row_bin", e.row_bin, got.row_bin);
      end
      frames_seen++;
    end
  end

  // APB write: setup then access, aligned to the falling edge
  task automatic apb_write(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_WIDTH:  cfg_width  = value & 32'h1FFF;
      REG_HEIGHT: cfg_height = value & 32'h1FFF;
      REG_MARGIN: cfg_margin = value & 32'hFF;
      default:    cfg_levels = value & 32'h7F;
    endcase
  endtask

  // wait for every pixel to be taken and every result to arrive, then settle
  task automatic drain();
    wait (pixel_queue.size() == 0 && !in_valid);
    wait (report_queue.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned m,
                              int unsigned lv);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_MARGIN, m);
    apb_write(REG_LEVELS, lv);
  endtask

  // one frame of random content; density chosen per frame
  task automatic queue_frame(int unsigned npix, int dens);
    for (int i = 0; i < npix; i++)
      pixel_queue.push_back(($urandom_range(0, 99) < dens) ? 8'($urandom_range(1, 255)) : 8'h00);
  endtask

  initial begin
    int unsigned w, h;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; out_ready = 0; mask_value = '0;
    hold_sender = 0; errors = 0; frames_seen = 0; pixels_sent = 0;
    cfg_width = 640; cfg_height = 480; cfg_margin = 42; cfg_levels = 5;
    keep_col_bin = 0; keep_row_bin = 0;
    clear_accumulators();
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: tiny frames, empty / full / single pixel / max-valued pixel
    set_geometry(4, 3, 0, 64);
    for (int i = 0; i < 12; i++) pixel_queue.push_back(8'h00);      // nothing found
    for (int i = 0; i < 12; i++) pixel_queue.push_back(i == 5 ? 8'hFF : 8'h00);
    drain();
    set_geometry(1, 1, 255, 0);                                     // margin wider than line
    pixel_queue.push_back(8'h01); pixel_queue.push_back(8'h80); pixel_queue.push_back(8'h00);
    drain();
    set_geometry(0, 0, 0, 127);                                     // zero dims, oversized levels
    pixel_queue.push_back(8'hFF);
    drain();

    // pause the sender until everything expected has come
    set_geometry(6, 4, 1, 3);
    queue_frame(24, 70);
    wait (pixel_queue.size() == 0 && !in_valid);
    hold_sender = 1;
    queue_frame(24, 50);
    wait (report_queue.size() == 0);
    hold_sender = 0;
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 14; ph++) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 8);
      set_geometry(w, h, (ph == 3) ? 255 : $urandom_range(0, 3),
                   (ph == 5) ? 1 : $urandom_range(0, 127));
      while (pixel_queue.size() < 40) queue_frame(clamp_dim(w) * clamp_dim(h),
                                                  $urandom_range(0, 100));
      drain();
    end

    $display("frames checked: %0d, pixels driven: %0d", frames_seen, pixels_sent);
    $display("covered empty, single and full frames, clamped sizes and levels, wide margins");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/bcbb_pkg.sv
rtl/bcbb_div.sv
rtl/bcbb_dp.sv
rtl/bcbb_ctrl.sv
rtl/blob_centroid_bbox_binner_top.sv
test/blob_centroid_bbox_binner_top_tb.sv
